FILE: hw/rtl/sdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdh_pkg: shared types and constants of the step detector
// Register indexes, reset values, fixed field widths and stage records.
// ----------------------------------------------------------------------------
package sdh_pkg;

	// Fixed field widths
	localparam int TIME_W  = 32;
	localparam int DAY_W   = 5;
	localparam int THR_W   = 17;
	localparam int IVL_W   = 16;
	localparam int TOTAL_W = 24;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ARM_LEVEL       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_REST_LEVEL      = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL_MS = 2'd2;

	// Register reset values
	localparam logic [THR_W-1:0] ARM_LEVEL_RST    = 17'd14000;
	localparam logic [THR_W-1:0] REST_LEVEL_RST   = 17'd10500;
	localparam logic [IVL_W-1:0] MIN_INTERVAL_RST = 16'd300;

	// Item kind
	typedef enum logic [0:0] {
		OP_SAMPLE = 1'b0,
		OP_CLEAR  = 1'b1
	} op_t;

	// Sideband fields that ride along with the axis lanes
	typedef struct packed {
		op_t              opcode;
		logic [TIME_W-1:0] now_ms;
		logic             clock_valid;
		logic [DAY_W-1:0] day_of_month;
	} hdr_t;

	// Merged item handed to the step tracker
	typedef struct packed {
		op_t              opcode;
		logic             above_high;
		logic             below_low;
		logic [TIME_W-1:0] now_ms;
		logic             clock_valid;
		logic [DAY_W-1:0] day_of_month;
	} merged_t;

endpackage : sdh_pkg
`default_nettype wire

FILE: hw/rtl/step_detector_hysteresis.sv
`timescale 1ns / 1ps
`default_nettype none
// An accepted item is registered in the lanes, the merge stage and the tracker, in that order.
// Throughput: one item per cycle while the output is not stalled; the step state is read and written in the
// tracker stage alone, so consecutive items follow without bubbles.
// Each stage holds its item only while the stage after it is full and stalled.
// Reset: arst_n clears stage valids, step state and registers to defaults.
// ----------------------------------------------------------------------------
// step_detector_hysteresis: two-threshold step counter with daily reset
// Three axis lanes, a merge stage and a step tracker with output register.
// ----------------------------------------------------------------------------
module step_detector_hysteresis
	import sdh_pkg::*;
#(
	parameter int SAMPLE_BITS = 16,
	parameter int COUNT_BITS  = 24
) (
	input  wire logic clk,
	input  wire logic arst_n,

	// tdata: accel_x, accel_y, accel_z, now_ms, clock_valid, day_of_month, zero pad
	input  wire logic [((3*SAMPLE_BITS+TIME_W+1+DAY_W+7)/8)*8-1:0] s_tdata,
	// tuser: opcode
	input  wire logic                  s_tuser,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,

	// tdata: step_total
	output logic [TOTAL_W-1:0]         m_tdata,
	// tuser: step_seen
	output logic                       m_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,

	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [THR_W-1:0]      cfg_data
);

	localparam int OFS_Y   = SAMPLE_BITS;
	localparam int OFS_Z   = 2*SAMPLE_BITS;
	localparam int OFS_NOW = 3*SAMPLE_BITS;
	localparam int OFS_CV  = OFS_NOW + TIME_W;
	localparam int OFS_DAY = OFS_CV + 1;

	logic [THR_W-1:0] high_thr_q;
	logic [THR_W-1:0] low_thr_q;
	logic [IVL_W-1:0] min_ivl_q;

	logic             valid_s1_q;
	logic             valid_s2_q;
	logic             ready_s1;
	logic             ready_s2;
	logic             ready_s3;
	logic             load_s1;
	logic             load_s2;

	logic [SAMPLE_BITS-1:0] abs_x_s1;
	logic [SAMPLE_BITS-1:0] abs_y_s1;
	logic [SAMPLE_BITS-1:0] abs_z_s1;
	hdr_t                   hdr_d;
	hdr_t                   hdr_s1;
	merged_t                merged_s2;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			high_thr_q <= ARM_LEVEL_RST;
			low_thr_q  <= REST_LEVEL_RST;
			min_ivl_q  <= MIN_INTERVAL_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ARM_LEVEL:       high_thr_q <= cfg_data;
				REG_REST_LEVEL:      low_thr_q  <= cfg_data;
				REG_MIN_INTERVAL_MS: min_ivl_q  <= cfg_data[IVL_W-1:0];
				default:             min_ivl_q  <= min_ivl_q;
			endcase
		end
	end

	// Pipeline flow control
	assign ready_s2 = !valid_s2_q || ready_s3;
	assign ready_s1 = !valid_s1_q || ready_s2;
	assign s_tready = ready_s1;
	assign load_s1  = s_tvalid && ready_s1;
	assign load_s2  = valid_s1_q && ready_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1_q <= 1'b0;
			valid_s2_q <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1_q <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2_q <= valid_s1_q;
			end
		end
	end

	// Sideband fields for stage 1
	assign hdr_d.opcode       = op_t'(s_tuser);
	assign hdr_d.now_ms       = s_tdata[OFS_NOW +: TIME_W];
	assign hdr_d.clock_valid  = s_tdata[OFS_CV];
	assign hdr_d.day_of_month = s_tdata[OFS_DAY +: DAY_W];

	always_ff @(posedge clk) begin
		if (load_s1) begin
			hdr_s1 <= hdr_d;
		end
	end

	// Axis lanes
	sdh_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_x (
		.clk    (clk),
		.en     (load_s1),
		.sample (s_tdata[0 +: SAMPLE_BITS]),
		.abs_s1 (abs_x_s1)
	);

	sdh_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_y (
		.clk    (clk),
		.en     (load_s1),
		.sample (s_tdata[OFS_Y +: SAMPLE_BITS]),
		.abs_s1 (abs_y_s1)
	);

	sdh_axis_lane #(.SAMPLE_BITS(SAMPLE_BITS)) u_lane_z (
		.clk    (clk),
		.en     (load_s1),
		.sample (s_tdata[OFS_Z +: SAMPLE_BITS]),
		.abs_s1 (abs_z_s1)
	);

	// Magnitude and threshold compare
	sdh_merge #(.SAMPLE_BITS(SAMPLE_BITS)) u_merge (
		.clk        (clk),
		.en         (load_s2),
		.abs_x      (abs_x_s1),
		.abs_y      (abs_y_s1),
		.abs_z      (abs_z_s1),
		.hdr_s1     (hdr_s1),
		.arm_level  (high_thr_q),
		.rest_level (low_thr_q),
		.merged_s2  (merged_s2)
	);

	// Step state and result
	sdh_tracker #(.COUNT_BITS(COUNT_BITS)) u_tracker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (valid_s2_q),
		.in_ready        (ready_s3),
		.merged_s2       (merged_s2),
		.min_interval_ms (min_ivl_q),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.step_total      (m_tdata),
		.step_seen       (m_tuser)
	);

endmodule : step_detector_hysteresis
`default_nettype wire

FILE: hw/rtl/sdh_axis_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdh_axis_lane: absolute value of one acceleration axis
// One lane per axis; the result is registered on the stage enable.
// ----------------------------------------------------------------------------
module sdh_axis_lane #(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [SAMPLE_BITS-1:0] sample,
	output logic      [SAMPLE_BITS-1:0] abs_s1
);

	logic [SAMPLE_BITS-1:0] abs_d;

	// Two's complement negate; the most negative code maps to 2^(SAMPLE_BITS-1)
	assign abs_d = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;

	always_ff @(posedge clk) begin
		if (en) begin
			abs_s1 <= abs_d;
		end
	end

endmodule : sdh_axis_lane
`default_nettype wire

FILE: hw/rtl/sdh_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdh_merge: combines the lane results
// Sums the three magnitudes and compares against both thresholds.
// ----------------------------------------------------------------------------
module sdh_merge
	import sdh_pkg::*;
#(
	parameter int SAMPLE_BITS = 16
) (
	input  wire logic                   clk,
	input  wire logic                   en,
	input  wire logic [SAMPLE_BITS-1:0] abs_x,
	input  wire logic [SAMPLE_BITS-1:0] abs_y,
	input  wire logic [SAMPLE_BITS-1:0] abs_z,
	input  wire hdr_t                   hdr_s1,
	input  wire logic [THR_W-1:0]       arm_level,
	input  wire logic [THR_W-1:0]       rest_level,
	output merged_t                     merged_s2
);

	localparam int MAG_W = SAMPLE_BITS + 2;
	localparam int CMP_W = (MAG_W > THR_W) ? MAG_W : THR_W;

	logic [MAG_W-1:0] mag;
	logic [CMP_W-1:0] mag_c;
	logic [CMP_W-1:0] high_c;
	logic [CMP_W-1:0] low_c;

	// Magnitude as the sum of absolute values
	assign mag = MAG_W'(abs_x) + MAG_W'(abs_y) + MAG_W'(abs_z);

	assign mag_c  = CMP_W'(mag);
	assign high_c = CMP_W'(arm_level);
	assign low_c  = CMP_W'(rest_level);

	always_ff @(posedge clk) begin
		if (en) begin
			merged_s2.opcode       <= hdr_s1.opcode;
			merged_s2.above_high   <= (mag_c > high_c);
			merged_s2.below_low    <= (mag_c < low_c);
			merged_s2.now_ms       <= hdr_s1.now_ms;
			merged_s2.clock_valid  <= hdr_s1.clock_valid;
			merged_s2.day_of_month <= hdr_s1.day_of_month;
		end
	end

endmodule : sdh_merge
`default_nettype wire

FILE: hw/rtl/sdh_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdh_tracker: step state and output register
// Holds arm flag, step count, last step time and the day tracking; drives
// the result item.
// ----------------------------------------------------------------------------
module sdh_tracker
	import sdh_pkg::*;
#(
	parameter int COUNT_BITS = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire merged_t          merged_s2,
	input  wire logic [IVL_W-1:0] min_interval_ms,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic [TOTAL_W-1:0]    step_total,
	output logic                  step_seen
);

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	logic                  armed_q;
	logic [TIME_W-1:0]     last_step_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  day_known_q;
	logic [DAY_W-1:0]      day_q;
	logic                  out_valid_q;
	logic                  seen_q;

	logic                  load;
	logic                  armed_d;
	logic [TIME_W-1:0]     last_step_d;
	logic [COUNT_BITS-1:0] count_d;
	logic [COUNT_BITS-1:0] count_day;
	logic                  day_known_d;
	logic [DAY_W-1:0]      day_d;
	logic                  seen_d;
	logic [TIME_W-1:0]     elapsed;

	assign in_ready = !out_valid_q || out_ready;
	assign load     = in_valid && in_ready;
	assign elapsed  = merged_s2.now_ms - last_step_q;

	// Next state for one item
	always_comb begin
		armed_d     = armed_q;
		last_step_d = last_step_q;
		count_d     = count_q;
		count_day   = count_q;
		day_known_d = day_known_q;
		day_d       = day_q;
		seen_d      = 1'b0;
		case (merged_s2.opcode)
			OP_CLEAR: begin
				count_d = '0;
			end
			OP_SAMPLE: begin
				// daily reset ahead of detection
				if (merged_s2.clock_valid) begin
					if (!day_known_q) begin
						day_known_d = 1'b1;
						day_d       = merged_s2.day_of_month;
					end else if (day_q != merged_s2.day_of_month) begin
						count_day = '0;
						day_d     = merged_s2.day_of_month;
					end
				end
				count_d = count_day;
				// two-threshold detection
				if (!armed_q) begin
					if (merged_s2.above_high) begin
						armed_d = 1'b1;
					end
				end else if (merged_s2.below_low) begin
					armed_d = 1'b0;
					if (elapsed > TIME_W'(min_interval_ms)) begin
						if (count_day != COUNT_MAX) begin
							count_d = count_day + 1'b1;
						end
						last_step_d = merged_s2.now_ms;
						seen_d      = 1'b1;
					end
				end
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q     <= 1'b0;
			last_step_q <= '0;
			count_q     <= '0;
			day_known_q <= 1'b0;
			day_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_ready) begin
				out_valid_q <= in_valid;
			end
			if (load) begin
				armed_q     <= armed_d;
				last_step_q <= last_step_d;
				count_q     <= count_d;
				day_known_q <= day_known_d;
				day_q       <= day_d;
			end
		end
	end

	// Result flag
	always_ff @(posedge clk) begin
		if (load) begin
			seen_q <= seen_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign step_seen  = seen_q;
	assign step_total = TOTAL_W'(count_q);

endmodule : sdh_tracker
`default_nettype wire

FILE: hw/rtl/sdh_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sdh_checker: port-level checks of the step detector
// Reset, stall and flow-control behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
module sdh_checker
	import sdh_pkg::*;
(
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_tvalid,
	input wire logic               s_tready,
	input wire logic [TOTAL_W-1:0] m_tdata,
	input wire logic               m_tuser,
	input wire logic               m_tvalid,
	input wire logic               m_tready,
	input wire logic               cfg_ready
);

	// No result while reset is held
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result item shown during reset");

	// A stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("stalled result item changed");

	// An empty output means the pipeline can take an item
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with output empty");

	// Items flow while the output drains every cycle
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		m_tready && $past(m_tready) |-> s_tready && cfg_ready)
		else $error("input stalled while output drains");

	// Input handshake
	logic in_fire;
	assign in_fire = s_tvalid && s_tready;

	a_accept_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |-> s_tready)
		else $error("item accepted without ready");

endmodule : sdh_checker

bind step_detector_hysteresis sdh_checker u_sdh_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.s_tvalid  (s_tvalid),
	.s_tready  (s_tready),
	.m_tdata   (m_tdata),
	.m_tuser   (m_tuser),
	.m_tvalid  (m_tvalid),
	.m_tready  (m_tready),
	.cfg_ready (cfg_ready)
);
`default_nettype wire
